// ===== design/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants for the preemptive schedule lower bound unit.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int MAX_OPS_DEF   = 64;
  localparam int TIME_BITS_DEF = 16;
  localparam logic [22:0] BOUND_MAX = 23'h7FFFFF;

  typedef struct packed {
    logic [15:0] release_time;
    logic [15:0] proc_time;
    logic [15:0] tail_time;
    logic        last_op;
  } op_word_t;

  typedef struct packed {
    logic [22:0] lower_bound;
    logic        overflow;
  } res_word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic all_done;
    logic scan_done;
  } status_t;

endpackage

// ===== design/psl_datapath.sv =====
// ----------------------------------------------------------------------------
// psl_datapath
// Operation store, scratch work store, scan accumulators and schedule update.
// ----------------------------------------------------------------------------
module psl_datapath #(
  parameter int MAX_OPS   = psl_pkg::MAX_OPS_DEF,
  parameter int TIME_BITS = psl_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  psl_pkg::op_word_t   in_data,
  input  psl_pkg::cmd_t       cmd,
  output psl_pkg::status_t    status,
  output psl_pkg::res_word_t  out_data
);
  import psl_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int AW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int CW = $clog2(MAX_OPS + 1);
  localparam int TW = TB + CW + 1;
  localparam int BW = TW + 1;
  localparam int SW = (BW > 23) ? BW : 23;

  logic [3*TB-1:0] op_mem  [MAX_OPS];
  logic [TB:0]     rem_mem [MAX_OPS];

  logic [CW-1:0] op_cnt, done_cnt, sidx;
  logic          ovf, scanning, rd_v;
  logic [AW-1:0] idx_q;
  logic [3*TB-1:0] op_q;
  logic [TB:0]     rem_q;
  logic [TW-1:0] t;
  logic [BW-1:0] bound;

  logic          best_found, nr_found;
  logic [TB-1:0] best_tail, best_rem;
  logic [AW-1:0] best_idx;
  logic [TW-1:0] nr;

  logic          scan_rd, store_ok;
  logic [TB-1:0] rel_q, tail_q;
  logic [TW-1:0] gap, t_fin;
  logic [BW-1:0] nb;
  logic          fin;
  logic          rem_we;
  logic [AW-1:0] rem_wa;
  logic [TB:0]   rem_wd;
  logic [SW-1:0] bx;

  assign store_ok = op_cnt < CW'(MAX_OPS);
  assign scan_rd  = scanning && (sidx < op_cnt);
  assign rel_q    = op_q[3*TB-1:2*TB];
  assign tail_q   = op_q[TB-1:0];

  assign gap   = nr - t;
  assign fin   = !nr_found || (TW'(best_rem) <= gap);
  assign t_fin = t + TW'(best_rem);
  assign nb    = BW'(t_fin) + BW'(best_tail);

  always_comb begin
    rem_we = 1'b0;
    rem_wa = best_idx;
    rem_wd = {1'b1, {TB{1'b0}}};
    if (cmd.load && store_ok) begin
      rem_we = 1'b1;
      rem_wa = op_cnt[AW-1:0];
      rem_wd = {1'b0, TB'(in_data.proc_time)};
    end else if (cmd.update && best_found) begin
      rem_we = 1'b1;
      if (!fin) rem_wd = {1'b0, best_rem - gap[TB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      op_mem[op_cnt[AW-1:0]] <= {TB'(in_data.release_time), TB'(in_data.proc_time),
                                 TB'(in_data.tail_time)};
    end
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (scan_rd) begin
      op_q  <= op_mem[sidx[AW-1:0]];
      rem_q <= rem_mem[sidx[AW-1:0]];
      idx_q <= sidx[AW-1:0];
    end
  end

  // scan: pick the ready op with the largest tail, find the next release
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_found <= 1'b0;
      nr_found   <= 1'b0;
    end else if (rd_v && !rem_q[TB]) begin
      if (TW'(rel_q) <= t) begin
        if (!best_found || tail_q > best_tail) begin
          best_found <= 1'b1;
          best_tail  <= tail_q;
          best_rem   <= rem_q[TB-1:0];
          best_idx   <= idx_q;
        end
      end else if (!nr_found || TW'(rel_q) < nr) begin
        nr_found <= 1'b1;
        nr       <= TW'(rel_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_cnt   <= '0;
      done_cnt <= '0;
      ovf      <= 1'b0;
      scanning <= 1'b0;
      rd_v     <= 1'b0;
      sidx     <= '0;
      t        <= '0;
      bound    <= '0;
    end else begin
      rd_v <= scan_rd;
      if (cmd.load) begin
        if (store_ok) op_cnt <= op_cnt + 1'b1;
        else          ovf    <= 1'b1;
      end
      if (cmd.scan_start) begin
        scanning <= 1'b1;
        sidx     <= '0;
      end else if (scan_rd) begin
        sidx <= sidx + 1'b1;
      end else if (!rd_v) begin
        scanning <= 1'b0;
      end
      if (cmd.update) begin
        if (best_found && fin) begin
          t        <= t_fin;
          done_cnt <= done_cnt + 1'b1;
          if (nb > bound) bound <= nb;
        end else if (nr_found) begin
          t <= nr;
        end
      end
      if (cmd.finish) begin
        op_cnt   <= '0;
        done_cnt <= '0;
        ovf      <= 1'b0;
        t        <= '0;
        bound    <= '0;
      end
    end
  end

  assign bx = SW'(bound);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.lower_bound <= (bx > SW'(BOUND_MAX)) ? BOUND_MAX : bx[22:0];
      out_data.overflow    <= ovf;
    end
  end

  assign status.all_done  = (done_cnt == op_cnt);
  assign status.scan_done = scanning && !scan_rd && !rd_v;

  a_done_le_cnt: assert property (@(posedge clk) disable iff (rst) done_cnt <= op_cnt)
    else $error("completed ops exceed stored ops");
  a_clear: assert property (@(posedge clk) disable iff (rst)
      cmd.finish |=> (op_cnt == '0) && (t == '0) && (bound == '0))
    else $error("set state not cleared after result");
  a_read_issued: assert property (@(posedge clk) disable iff (rst) rd_v |-> (sidx != '0))
    else $error("read data without issued address");

endmodule

// ===== design/psl_ctrl.sv =====
// ----------------------------------------------------------------------------
// psl_ctrl
// Sequencer: load, repeated scan and update passes, result hand-off.
// ----------------------------------------------------------------------------
module psl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  psl_pkg::status_t status,
  output psl_pkg::cmd_t    cmd
);
  import psl_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = ST_START;
        end
      end
      ST_START: begin
        if (status.all_done) begin
          state_next = ST_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_START;
      end
      ST_OUT: begin
        // hold until the previous word has left the output register
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

// ===== design/preemptive_schedule_lower_bound_unit.sv =====
// ----------------------------------------------------------------------------
// preemptive_schedule_lower_bound_unit
// Jackson preemptive single-machine lower bound over one set of operations.
//
//   channel | signals                          | word
//   input   | in_valid, in_ready, in_data      | one operation, last_op ends set
//   output  | out_valid, out_ready, out_data   | lower bound and overflow flag
//
// Loading takes one cycle per operation. After the last one, each schedule
// event costs one scan of all n stored ops (one memory read per cycle) plus
// start and update steps, with at most 2n events. Reset (rst, synchronous)
// clears counters, flags, time and bound; stores need no clearing.
// A waiting result does not block loading of the next set.
// ----------------------------------------------------------------------------
module preemptive_schedule_lower_bound_unit #(
  parameter int MAX_OPS   = psl_pkg::MAX_OPS_DEF,
  parameter int TIME_BITS = psl_pkg::TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  psl_pkg::op_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output psl_pkg::res_word_t out_data
);
  import psl_pkg::*;

  cmd_t    cmd;
  status_t status;

  psl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  psl_datapath #(
    .MAX_OPS   (MAX_OPS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== verif/psl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psl_checker
// Watches the operation and bound channels of the lower bound unit, rebuilds
// the preemptive schedule for every finished set and compares each bound word.
// ----------------------------------------------------------------------------
module psl_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  psl_pkg::op_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  psl_pkg::res_word_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import psl_pkg::*;

  localparam int OPS = MAX_OPS_DEF;

  logic [15:0] set_rel [OPS];
  logic [15:0] set_proc [OPS];
  logic [15:0] set_tail [OPS];
  int          set_size;
  logic        set_ovf;
  res_word_t   bound_q [$];

  assign pending = bound_q.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Jackson schedule: release order, largest tail runs, preempt at next release.
  function automatic logic [22:0] jackson_bound();
    int          order [OPS];
    longint      left [OPS];
    int          rdy [OPS];
    int          nrdy, pos, v, j, top, cur;
    longint      now, nxt, gap, best, nb;
    best = 0;
    nrdy = 0;
    pos = 0;
    for (int i = 0; i < set_size; i++) begin
      v = i;
      j = i;
      while (j > 0 && set_rel[order[j-1]] > set_rel[v]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
      left[i] = set_proc[i];
    end
    if (set_size == 0) return '0;
    now = set_rel[order[0]];
    while (pos < set_size) begin
      while (pos < set_size && set_rel[order[pos]] == now) begin
        cur = order[pos];
        for (int k = 0; k < nrdy; k++) begin
          if (set_tail[cur] < set_tail[rdy[k]]) begin
            top = rdy[k];
            rdy[k] = cur;
            cur = top;
          end
        end
        rdy[nrdy++] = cur;
        pos++;
      end
      nxt = (pos < set_size) ? longint'(set_rel[order[pos]]) : -1;
      while (nrdy > 0) begin
        top = rdy[nrdy-1];
        gap = nxt - now;
        if (nxt >= 0 && left[top] > gap) begin
          left[top] -= gap;
          break;
        end
        now += left[top];
        nb = now + set_tail[top];
        if (nb > best) best = nb;
        left[top] = 0;
        nrdy--;
      end
      if (nxt >= 0) now = nxt;
    end
    return (best > BOUND_MAX) ? BOUND_MAX : best[22:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      set_size = 0;
      set_ovf = 1'b0;
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (set_size < OPS) begin
          set_rel[set_size] = in_data.release_time;
          set_proc[set_size] = in_data.proc_time;
          set_tail[set_size] = in_data.tail_time;
          set_size = set_size + 1;
        end else begin
          set_ovf = 1'b1;
        end
        if (in_data.last_op) begin
          bound_q.push_back('{lower_bound: jackson_bound(), overflow: set_ovf});
          set_size = 0;
          set_ovf = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        if (bound_q.size() == 0) begin
          report_mismatch("unexpected word", out_data.lower_bound, -1);
        end else begin
          if (out_data.lower_bound !== bound_q[0].lower_bound)
            report_mismatch("lower_bound", out_data.lower_bound, bound_q[0].lower_bound);
          if (out_data.overflow !== bound_q[0].overflow)
            report_mismatch("overflow", out_data.overflow, bound_q[0].overflow);
          void'(bound_q.pop_front());
        end
      end
    end
  end
endmodule

// ===== verif/tb_preemptive_schedule_lower_bound_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_preemptive_schedule_lower_bound_unit
// Feeds operation sets of varied size and timing through the lower bound unit
// under several idling patterns; the checker predicts and compares bounds.
// ----------------------------------------------------------------------------
module tb_preemptive_schedule_lower_bound_unit;
  import psl_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  op_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  res_word_t out_data;
  int        fail_count;
  int        pending;
  int        send_idle;
  int        recv_stall;

  preemptive_schedule_lower_bound_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  psl_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_preemptive_schedule_lower_bound_unit failed");
    $finish;
  end

  // Random receiver stall.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Hold one word until accepted, with optional idle cycles before it.
  task automatic send_op(input logic [15:0] r, input logic [15:0] p,
                         input logic [15:0] t, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{release_time: r, proc_time: p, tail_time: t, last_op: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_time(input int scale);
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(scale));
    endcase
  endfunction

  task automatic send_set(input int n);
    int scale;
    scale = ($urandom_range(3) == 0) ? 65535 : $urandom_range(40);
    for (int i = 0; i < n; i++)
      send_op(rand_time(scale), rand_time(scale), rand_time(scale), i == n - 1);
  endtask

  int sent;
  int set_n;

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single ops at the field extremes and in alternating bit patterns
    send_op(16'd0, 16'd0, 16'd0, 1'b1);
    send_op(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_op(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    send_op(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    // equal releases and equal tails
    send_op(16'd5, 16'd3, 16'd7, 1'b0);
    send_op(16'd5, 16'd4, 16'd7, 1'b0);
    send_op(16'd5, 16'd0, 16'd9, 1'b1);
    // preemption by a later release with a larger tail, plus an idle gap
    send_op(16'd0, 16'd10, 16'd1, 1'b0);
    send_op(16'd3, 16'd2, 16'd20, 1'b0);
    send_op(16'd30, 16'd1, 16'd0, 1'b1);
    // descending releases, large values
    send_op(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_op(16'hFF00, 16'hFFFF, 16'hFFFF, 1'b0);
    send_op(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    sent = 13;

    // full store, then overflow with last on a dropped word
    send_set(64);
    for (int i = 0; i < 66; i++)
      send_op(16'($urandom), 16'($urandom), 16'($urandom), i == 65);
    // many long ops: the largest bound the fields allow, still below BOUND_MAX
    for (int i = 0; i < 64; i++) send_op(16'hFFFF, 16'hFFFF, 16'hFFFF, i == 63);
    sent += 194;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 65 : (ph == 3) ? 13 : 0;
      recv_stall = (ph == 2) ? 65 : (ph == 3) ? 13 : 0;
      repeat (14) begin
        if (sent >= 550) break;
        set_n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        send_set(set_n);
        sent += set_n;
      end
    end
    in_valid <= 1'b0;
    recv_stall = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("tb_preemptive_schedule_lower_bound_unit passed");
    else
      $display("tb_preemptive_schedule_lower_bound_unit failed");
    $finish;
  end
endmodule

// ===== preemptive_schedule_lower_bound_unit.f =====
design/psl_pkg.sv
design/psl_datapath.sv
design/psl_ctrl.sv
design/preemptive_schedule_lower_bound_unit.sv
verif/psl_checker.sv
verif/tb_preemptive_schedule_lower_bound_unit.sv
